// ===== hw/rtl/kmul_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmul_pkg
// Shared widths, operand selector codes and the sequencer control bundle for
// the Karatsuba multiplier.
// -----------------------------------------------------------------------------
package kmul_pkg;

	// Operand and split widths; the high half is never wider than the low half
	localparam int OPERAND_WIDTH = 32;
	localparam int HI_W          = OPERAND_WIDTH / 2;
	localparam int LO_W          = OPERAND_WIDTH - HI_W;
	localparam int SUM_W         = LO_W + 1;
	localparam int PART_W        = 2 * SUM_W;
	localparam int PROD_W        = 2 * OPERAND_WIDTH;

	// Stream data widths, whole bytes
	localparam int S_TDATA_W = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W = ((PROD_W + 7) / 8) * 8;

	// Which pair of half-operands feeds the shared multiplier
	typedef enum logic [1:0] {
		SEL_LO  = 2'd0,
		SEL_HI  = 2'd1,
		SEL_SUM = 2'd2
	} opsel_t;

	// Control from the sequencer to the datapath
	typedef struct packed {
		logic   in_ready;  // capture a new operand pair
		opsel_t sel;       // multiplier operand select
		logic   cap_z0;    // store low partial product
		logic   cap_z2;    // store high partial product
		logic   cap_mid;   // store middle term
		logic   load_out;  // load the final product into the output register
		logic   at_fin;    // final combine step is pending
	} ctrl_t;

endpackage

// ===== hw/rtl/kmul_mult.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmul_mult
// Shared unsigned half-width multiplier with a registered product; forms each
// of the three Karatsuba partial products in turn.
// -----------------------------------------------------------------------------
module kmul_mult
	import kmul_pkg::*;
(
	input  logic              clk,
	input  logic [SUM_W-1:0]  mul_x,
	input  logic [SUM_W-1:0]  mul_y,
	output logic [PART_W-1:0] mul_p
);

	logic [PART_W-1:0] prod_q;

	// Register the product every cycle
	always_ff @(posedge clk) begin
		prod_q <= PART_W'(mul_x) * PART_W'(mul_y);
	end

	assign mul_p = prod_q;

endmodule

// ===== hw/rtl/kmul_seq.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// kmul_seq
// Sequencer: steps the shared multiplier through low, high and sum products,
// then the middle-term and final combine steps.
// -----------------------------------------------------------------------------
module kmul_seq
	import kmul_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	input  logic  out_free,
	output ctrl_t ctrl
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_MUL_LO  = 6'b000010,
		ST_MUL_HI  = 6'b000100,
		ST_MUL_SUM = 6'b001000,
		ST_MID     = 6'b010000,
		ST_FIN     = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_MUL_LO;
			ST_MUL_LO:  state_d = ST_MUL_HI;
			ST_MUL_HI:  state_d = ST_MUL_SUM;
			ST_MUL_SUM: state_d = ST_MID;
			ST_MID:     state_d = ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Decode controls; each product is registered and lands in the cycle after its select
	always_comb begin
		ctrl          = '0;
		ctrl.sel      = SEL_LO;
		ctrl.in_ready = (state_q == ST_IDLE);
		ctrl.at_fin   = (state_q == ST_FIN);
		ctrl.load_out = (state_q == ST_FIN) && out_free;
		case (state_q)
			ST_MUL_LO:  ctrl.sel = SEL_LO;
			ST_MUL_HI: begin
				ctrl.sel    = SEL_HI;
				ctrl.cap_z0 = 1'b1;
			end
			ST_MUL_SUM: begin
				ctrl.sel    = SEL_SUM;
				ctrl.cap_z2 = 1'b1;
			end
			ST_MID:     ctrl.cap_mid = 1'b1;
			default:    ctrl.sel = SEL_LO;
		endcase
	end

endmodule

// ===== hw/rtl/karatsuba_multiplier.sv =====
`timescale 1ns / 1ps
// Flow: an input beat passes MUL_LO, MUL_HI, MUL_SUM, MID and FIN before the product beat;
//   FIN holds while the output register is still held by the consumer.
// Rate: a new operand pair is taken only back in IDLE, after the accept state, the single
//   shared multiplier taking the three partial products in turn and two combine steps.
// Reset: arst_n clears the sequencer and the output valid; data registers are not reset.
// -----------------------------------------------------------------------------
// karatsuba_multiplier
// Full unsigned product of two factors by one level of Karatsuba splitting:
// z0 = lo*lo, z2 = hi*hi, z1 = (lo+hi)*(lo+hi), product = z2<<2m + (z1-z2-z0)<<m + z0.
// -----------------------------------------------------------------------------
module karatsuba_multiplier
	import kmul_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // operand_a, operand_b
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // product
);

	ctrl_t ctrl;

	logic [OPERAND_WIDTH-1:0] a_q;
	logic [OPERAND_WIDTH-1:0] b_q;
	logic [PART_W-1:0]        z0_q;
	logic [PART_W-1:0]        z2_q;
	logic [PART_W-1:0]        mid_q;
	logic [PROD_W-1:0]        prod_q;
	logic                     out_valid_q;

	logic [SUM_W-1:0]  mul_x;
	logic [SUM_W-1:0]  mul_y;
	logic [PART_W-1:0] mul_p;
	logic [PROD_W-1:0] final_sum;
	logic              out_free;

	assign out_free = !out_valid_q || m_tready;

	kmul_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.ctrl     (ctrl)
	);

	// Capture the operand pair on an input beat
	always_ff @(posedge clk) begin
		if (s_tvalid && ctrl.in_ready) begin
			a_q <= s_tdata[OPERAND_WIDTH-1:0];
			b_q <= s_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
		end
	end

	// Select the half-operands for the shared multiplier
	always_comb begin
		case (ctrl.sel)
			SEL_LO: begin
				mul_x = SUM_W'(a_q[LO_W-1:0]);
				mul_y = SUM_W'(b_q[LO_W-1:0]);
			end
			SEL_HI: begin
				mul_x = SUM_W'(a_q[OPERAND_WIDTH-1:LO_W]);
				mul_y = SUM_W'(b_q[OPERAND_WIDTH-1:LO_W]);
			end
			SEL_SUM: begin
				mul_x = SUM_W'(a_q[LO_W-1:0]) + SUM_W'(a_q[OPERAND_WIDTH-1:LO_W]);
				mul_y = SUM_W'(b_q[LO_W-1:0]) + SUM_W'(b_q[OPERAND_WIDTH-1:LO_W]);
			end
			default: begin
				mul_x = '0;
				mul_y = '0;
			end
		endcase
	end

	kmul_mult u_mult (
		.clk   (clk),
		.mul_x (mul_x),
		.mul_y (mul_y),
		.mul_p (mul_p)
	);

	// Hold partial products and form the middle term
	always_ff @(posedge clk) begin
		if (ctrl.cap_z0) begin
			z0_q <= mul_p;
		end
		if (ctrl.cap_z2) begin
			z2_q <= mul_p;
		end
		if (ctrl.cap_mid) begin
			mid_q <= mul_p - z2_q - z0_q;
		end
	end

	// z0 fits below 2m, so the outer terms join by concatenation
	assign final_sum = {z2_q[2*HI_W-1:0], z0_q[2*LO_W-1:0]}
	                 + (PROD_W'(mid_q) << LO_W);

	// Output register
	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			prod_q <= final_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = M_TDATA_W'(prod_q);

`ifndef SYNTHESIS
	a_busy_after_beat : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while a product is in progress");

	a_fin_after_five : assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##5 ctrl.at_fin)
		else $error("combine step not reached five cycles after an input beat");

	a_fin_holds : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.at_fin && !out_free |=> ctrl.at_fin && !s_tready)
		else $error("final product dropped while the output register was held");

	a_load_shows : assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load_out |=> m_tvalid && m_tdata == M_TDATA_W'($past(final_sum)))
		else $error("loaded product not presented on the output");
`endif

endmodule
